>>> rtl/assert_macros.svh
// Assertion helpers for the files that check their own logic.
// Both expect signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define APC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a property in the next cycle.
`define APC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> rtl/apc_pkg.sv
package apc_pkg;

  // Largest limit that is honoured; anything above it is clamped.
  localparam int MAX_LIMIT = 65535;

  localparam int LIM_W   = 16;
  localparam int COUNT_W = 13;

  // Largest limit the 16-bit request can carry once clamped.
  localparam int EFF_MAX   = (MAX_LIMIT < 65535) ? MAX_LIMIT : 65535;
  localparam int MAP_DEPTH = EFF_MAX + 1;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  // Square roots of a limit need half the bits plus one to reach the first overshoot.
  localparam int ROOT_W = LIM_W / 2 + 1;
  localparam int SQ_W   = LIM_W + 1;
  localparam int FORM_W = LIM_W + 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Residues modulo twelve that select a toggle for each quadratic form.
  localparam logic [3:0] RES_A_LO = 4'd1;
  localparam logic [3:0] RES_A_HI = 4'd5;
  localparam logic [3:0] RES_B    = 4'd7;
  localparam logic [3:0] RES_C    = 4'd11;
  localparam logic [3:0] MOD_LAST = 4'd11;

  // Square elimination and counting start here; 2 and 3 are added directly.
  localparam int FIRST_SIEVED = 5;

  typedef enum logic {
    OP_TOGGLE,
    OP_FINISH
  } op_kind_t;

  // One queue entry: a toggle address, or the closing marker that carries the limit.
  typedef struct packed {
    op_kind_t          kind;
    logic [LIM_W-1:0]  val;
    logic              clamp;
  } op_t;

  typedef enum logic [1:0] {
    FORM_A,
    FORM_B,
    FORM_C
  } form_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_GEN,
    F_FIN
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_TOG,
    B_ELIM_TEST,
    B_ELIM_CHK,
    B_ELIM_CLR,
    B_COUNT,
    B_TAIL,
    B_OUT
  } back_state_t;

  // Square of a value modulo twelve, given the value modulo twelve.
  function automatic logic [3:0] sq_mod12(input logic [3:0] m);
    logic [3:0] r;
    case (m)
      4'd0, 4'd6:                r = 4'd0;
      4'd1, 4'd5, 4'd7, 4'd11:   r = 4'd1;
      4'd2, 4'd4, 4'd8, 4'd10:   r = 4'd4;
      4'd3, 4'd9:                r = 4'd9;
      default:                   r = 4'd0;
    endcase
    return r;
  endfunction

  // Residue modulo twelve of a value below 72.
  function automatic logic [3:0] mod12_small(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    if (t >= 6'd48) t = t - 6'd48;
    if (t >= 6'd24) t = t - 6'd24;
    if (t >= 6'd12) t = t - 6'd12;
    return t[3:0];
  endfunction

endpackage

>>> rtl/atkin_prime_counter.sv
// Work per request: quadratic-form generation over every (x, y) pair whose squares stay within
// the limit, then the square elimination, reading each number from 5 whose square is within the
// limit and clearing the multiples of each survivor's square, and finally counting up to the limit.
// Requests take their turns on the single bit map, so the back end works on one at a time.
// Reset: synchronous, active high; afterwards a pass over the whole map clears it before any request
// is worked on, while a first request may already be accepted and queued.
`include "assert_macros.svh"

module atkin_prime_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [apc_pkg::LIM_W-1:0]     limit,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [apc_pkg::COUNT_W-1:0]   prime_count,
  output logic                          clamped
);

  // The front end takes a request transaction, clamps the limit and walks every (x, y) pair,
  // testing one quadratic form per cycle while the queue has room. Each form that lands on a candidate under the
  // mod-12 rules becomes a toggle entry in the queue; a closing entry carries the limit.
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  apc_pkg::op_t  q_op;
  apc_pkg::op_t  q_head;

  apc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .limit     (limit),
    .q_push    (q_push),
    .q_op      (q_op),
    .q_full    (q_full)
  );

  // A short queue lets the front end keep generating while the back end is busy with a
  // read-modify-write, and lets the next request start before the previous result is taken.
  apc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_op),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .valid   (q_valid)
  );

  // The back end owns the candidate bit map. It applies toggles, and on the closing entry
  // clears multiples of the squares of the surviving numbers from 5 upward, then counts
  // the marked entries while wiping them so that the map is blank for the next request.
  apc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .prime_count (prime_count),
    .clamped     (clamped)
  );

  // The front end must never write into a full queue, nor the back end read an empty one.
  `APC_ASSERT(a_no_push_full, !(q_push && q_full), "queue written while full")
  `APC_ASSERT(a_no_pop_empty, !(q_pop && !q_valid), "queue read while empty")
  // Once a request is taken the front end is busy with it.
  `APC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "front end idle")
  // The back end holds off the queue while a result waits to be taken.
  `APC_ASSERT(a_hold_during_result, !(res_valid && q_pop), "queue read while a result is pending")

endmodule

>>> rtl/apc_queue.sv
module apc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  apc_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output apc_pkg::op_t head,
  output logic         valid
);

  apc_pkg::op_t                 entries [apc_pkg::QUEUE_DEPTH];
  logic [apc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [apc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [apc_pkg::QCNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == apc_pkg::QPTR_W'(apc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == apc_pkg::QPTR_W'(apc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  assign head  = entries[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == apc_pkg::QCNT_W'(apc_pkg::QUEUE_DEPTH));

endmodule

>>> rtl/apc_front.sv
module apc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [apc_pkg::LIM_W-1:0]   limit,
  output logic                        q_push,
  output apc_pkg::op_t                q_op,
  input  logic                        q_full
);

  apc_pkg::front_state_t state;
  apc_pkg::front_state_t state_next;

  logic [apc_pkg::LIM_W-1:0]  lim;
  logic                       clamp;
  logic [apc_pkg::ROOT_W-1:0] x;
  logic [apc_pkg::ROOT_W-1:0] y;
  logic [apc_pkg::SQ_W-1:0]   xx;
  logic [apc_pkg::SQ_W-1:0]   yy;
  logic [3:0]                 xm;
  logic [3:0]                 ym;
  apc_pkg::form_t             form;

  logic                       over;
  logic [apc_pkg::LIM_W-1:0]  lim_in;
  logic                       load;
  logic                       step_x;
  logic                       adv;
  logic                       x_done;
  logic                       y_done;
  logic                       hit;
  logic [3:0]                 sa;
  logic [3:0]                 sb;
  logic [3:0]                 r_a;
  logic [3:0]                 r_b;
  logic [3:0]                 r_c;
  logic [apc_pkg::FORM_W-1:0] n_a;
  logic [apc_pkg::FORM_W-1:0] n_b;
  logic [apc_pkg::FORM_W-1:0] n_c;
  logic [apc_pkg::FORM_W-1:0] n_sel;
  logic [apc_pkg::FORM_W-1:0] lim_w;
  logic [apc_pkg::FORM_W-1:0] xx_w;
  logic [apc_pkg::FORM_W-1:0] yy_w;

  // Requests above the largest honoured limit are brought down to it.
  assign over   = ({16'b0, limit} > 32'(apc_pkg::MAX_LIMIT));
  assign lim_in = over ? apc_pkg::LIM_W'(apc_pkg::EFF_MAX) : limit;

  assign xx_w  = apc_pkg::FORM_W'(xx);
  assign yy_w  = apc_pkg::FORM_W'(yy);
  assign lim_w = apc_pkg::FORM_W'(lim);

  assign n_a = (xx_w << 2) + yy_w;
  assign n_b = (xx_w << 1) + xx_w + yy_w;
  assign n_c = (xx_w << 1) + xx_w - yy_w;

  // Residues follow from x and y modulo twelve, so no wide reduction is needed.
  assign sa  = apc_pkg::sq_mod12(xm);
  assign sb  = apc_pkg::sq_mod12(ym);
  assign r_a = apc_pkg::mod12_small({sa, 2'b00} + {2'b00, sb});
  assign r_b = apc_pkg::mod12_small({1'b0, sa, 1'b0} + {2'b00, sa} + {2'b00, sb});
  assign r_c = apc_pkg::mod12_small({1'b0, sa, 1'b0} + {2'b00, sa} + 6'd12 - {2'b00, sb});

  assign x_done = (xx > apc_pkg::SQ_W'(lim));
  assign y_done = (yy > apc_pkg::SQ_W'(lim));

  always_comb begin
    hit   = 1'b0;
    n_sel = n_a;
    case (form)
      apc_pkg::FORM_A: begin
        n_sel = n_a;
        hit   = (n_a <= lim_w) && ((r_a == apc_pkg::RES_A_LO) || (r_a == apc_pkg::RES_A_HI));
      end
      apc_pkg::FORM_B: begin
        n_sel = n_b;
        hit   = (n_b <= lim_w) && (r_b == apc_pkg::RES_B);
      end
      apc_pkg::FORM_C: begin
        n_sel = n_c;
        hit   = (x > y) && (n_c <= lim_w) && (r_c == apc_pkg::RES_C);
      end
      default: begin
        n_sel = n_a;
        hit   = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      apc_pkg::F_IDLE: begin
        if (req_valid) begin
          state_next = (lim_in < apc_pkg::LIM_W'(2)) ? apc_pkg::F_FIN : apc_pkg::F_GEN;
        end
      end
      apc_pkg::F_GEN: begin
        if (x_done) state_next = apc_pkg::F_FIN;
      end
      apc_pkg::F_FIN: begin
        if (!q_full) state_next = apc_pkg::F_IDLE;
      end
      default: state_next = apc_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    load       = 1'b0;
    step_x     = 1'b0;
    adv        = 1'b0;
    q_push     = 1'b0;
    q_op.kind  = apc_pkg::OP_TOGGLE;
    q_op.val   = n_sel[apc_pkg::LIM_W-1:0];
    q_op.clamp = clamp;
    case (state)
      apc_pkg::F_IDLE: begin
        req_stall = 1'b0;
        load      = req_valid;
      end
      apc_pkg::F_GEN: begin
        if (!x_done) begin
          if (y_done) begin
            step_x = 1'b1;
          end else begin
            adv    = !hit || !q_full;
            q_push = hit && !q_full;
          end
        end
      end
      apc_pkg::F_FIN: begin
        q_push    = !q_full;
        q_op.kind = apc_pkg::OP_FINISH;
        q_op.val  = lim;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apc_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lim   <= lim_in;
      clamp <= over;
      x     <= apc_pkg::ROOT_W'(1);
      xx    <= apc_pkg::SQ_W'(1);
      xm    <= 4'd1;
      y     <= apc_pkg::ROOT_W'(1);
      yy    <= apc_pkg::SQ_W'(1);
      ym    <= 4'd1;
      form  <= apc_pkg::FORM_A;
    end else if (step_x) begin
      // (x+1)^2 = x^2 + 2x + 1
      x    <= x + 1'b1;
      xx   <= xx + apc_pkg::SQ_W'({x, 1'b1});
      xm   <= (xm == apc_pkg::MOD_LAST) ? 4'd0 : xm + 4'd1;
      y    <= apc_pkg::ROOT_W'(1);
      yy   <= apc_pkg::SQ_W'(1);
      ym   <= 4'd1;
      form <= apc_pkg::FORM_A;
    end else if (adv) begin
      case (form)
        apc_pkg::FORM_A: form <= apc_pkg::FORM_B;
        apc_pkg::FORM_B: form <= apc_pkg::FORM_C;
        default: begin
          form <= apc_pkg::FORM_A;
          y    <= y + 1'b1;
          yy   <= yy + apc_pkg::SQ_W'({y, 1'b1});
          ym   <= (ym == apc_pkg::MOD_LAST) ? 4'd0 : ym + 4'd1;
        end
      endcase
    end
  end

endmodule

>>> rtl/apc_back.sv
module apc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  apc_pkg::op_t                  q_head,
  output logic                          q_pop,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [apc_pkg::COUNT_W-1:0]   prime_count,
  output logic                          clamped
);

  apc_pkg::back_state_t state;
  apc_pkg::back_state_t state_next;

  logic                         map_bits [apc_pkg::MAP_DEPTH];
  logic                         rd_data;
  logic                         mem_we;
  logic                         mem_wd;
  logic [apc_pkg::MAP_AW-1:0]   mem_wa;
  logic [apc_pkg::MAP_AW-1:0]   mem_ra;

  logic [apc_pkg::LIM_W-1:0]    cur_lim;
  logic                         cur_clamp;
  logic [apc_pkg::MAP_AW-1:0]   tog_addr;
  logic [apc_pkg::ROOT_W-1:0]   en;
  logic [apc_pkg::SQ_W-1:0]     sq;
  logic [apc_pkg::SQ_W-1:0]     k;
  logic [apc_pkg::MAP_AW-1:0]   a;
  logic                         pend;
  logic                         pend_ge5;
  logic [apc_pkg::COUNT_W-1:0]  total;

  logic                         sq_over;
  logic [apc_pkg::SQ_W-1:0]     k_nx;
  logic                         k_end;
  logic                         a_last;
  logic                         clr_last;
  logic                         count_hit;

  assign sq_over   = (sq > apc_pkg::SQ_W'(cur_lim));
  assign k_nx      = k + sq;
  assign k_end     = (k_nx > apc_pkg::SQ_W'(cur_lim));
  assign a_last    = (apc_pkg::LIM_W'(a) == cur_lim);
  assign clr_last  = (a == apc_pkg::MAP_AW'(apc_pkg::MAP_DEPTH - 1));
  assign count_hit = pend && pend_ge5 && rd_data;

  always_comb begin
    state_next = state;
    case (state)
      apc_pkg::B_CLEAR: begin
        if (clr_last) state_next = apc_pkg::B_IDLE;
      end
      apc_pkg::B_IDLE: begin
        if (q_valid) begin
          state_next = (q_head.kind == apc_pkg::OP_TOGGLE) ? apc_pkg::B_TOG
                                                            : apc_pkg::B_ELIM_TEST;
        end
      end
      apc_pkg::B_TOG:       state_next = apc_pkg::B_IDLE;
      apc_pkg::B_ELIM_TEST: state_next = sq_over ? apc_pkg::B_COUNT : apc_pkg::B_ELIM_CHK;
      apc_pkg::B_ELIM_CHK:  state_next = rd_data ? apc_pkg::B_ELIM_CLR : apc_pkg::B_ELIM_TEST;
      apc_pkg::B_ELIM_CLR: begin
        if (k_end) state_next = apc_pkg::B_ELIM_TEST;
      end
      apc_pkg::B_COUNT: begin
        if (a_last) state_next = apc_pkg::B_TAIL;
      end
      apc_pkg::B_TAIL:      state_next = apc_pkg::B_OUT;
      apc_pkg::B_OUT: begin
        if (!res_stall) state_next = apc_pkg::B_IDLE;
      end
      default:              state_next = apc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_wd    = 1'b0;
    mem_wa    = a;
    mem_ra    = apc_pkg::MAP_AW'(en);
    case (state)
      apc_pkg::B_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = a;
      end
      apc_pkg::B_IDLE: begin
        q_pop  = q_valid;
        mem_ra = q_head.val[apc_pkg::MAP_AW-1:0];
      end
      apc_pkg::B_TOG: begin
        mem_we = 1'b1;
        mem_wa = tog_addr;
        mem_wd = !rd_data;
      end
      apc_pkg::B_ELIM_TEST: begin
        mem_ra = apc_pkg::MAP_AW'(en);
      end
      apc_pkg::B_ELIM_CLR: begin
        mem_we = 1'b1;
        mem_wa = k[apc_pkg::MAP_AW-1:0];
      end
      apc_pkg::B_COUNT: begin
        // Read for the count and clear behind it, leaving the map blank for the next request.
        mem_ra = a;
        mem_we = 1'b1;
        mem_wa = a;
      end
      apc_pkg::B_OUT: begin
        res_valid = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_bits[mem_wa] <= mem_wd;
    end
    rd_data <= map_bits[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apc_pkg::B_CLEAR;
      a     <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == apc_pkg::B_COUNT);
      case (state)
        apc_pkg::B_CLEAR: a <= clr_last ? '0 : a + 1'b1;
        apc_pkg::B_IDLE:  a <= '0;
        apc_pkg::B_COUNT: a <= a + 1'b1;
        default:          a <= a;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pend_ge5 <= (a >= apc_pkg::MAP_AW'(apc_pkg::FIRST_SIEVED));
    case (state)
      apc_pkg::B_IDLE: begin
        tog_addr <= q_head.val[apc_pkg::MAP_AW-1:0];
        if (q_valid && (q_head.kind == apc_pkg::OP_FINISH)) begin
          cur_lim   <= q_head.val;
          cur_clamp <= q_head.clamp;
          en        <= apc_pkg::ROOT_W'(apc_pkg::FIRST_SIEVED);
          sq        <= apc_pkg::SQ_W'(apc_pkg::FIRST_SIEVED * apc_pkg::FIRST_SIEVED);
          total     <= apc_pkg::COUNT_W'(q_head.val >= apc_pkg::LIM_W'(2))
                     + apc_pkg::COUNT_W'(q_head.val >= apc_pkg::LIM_W'(3));
        end
      end
      apc_pkg::B_ELIM_CHK: begin
        if (rd_data) begin
          k <= sq;
        end else begin
          en <= en + 1'b1;
          sq <= sq + apc_pkg::SQ_W'({en, 1'b1});
        end
      end
      apc_pkg::B_ELIM_CLR: begin
        k <= k_nx;
        if (k_end) begin
          en <= en + 1'b1;
          sq <= sq + apc_pkg::SQ_W'({en, 1'b1});
        end
      end
      apc_pkg::B_COUNT, apc_pkg::B_TAIL: begin
        if (count_hit) total <= total + 1'b1;
      end
      default: begin
        total <= total;
      end
    endcase
  end

  assign prime_count = total;
  assign clamped     = cur_clamp;

endmodule
